### src/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg: shared types and constants for the point-segment distance unit
// Result field widths and region codes.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int DIST_WIDTH   = 26;
  localparam int REGION_WIDTH = 2;
  localparam logic [DIST_WIDTH-1:0] DIST_MAX = 26'h3FF_FFFF;

  typedef enum logic [REGION_WIDTH-1:0] {
    REGION_PERP  = 2'd0,
    REGION_END_B = 2'd1,
    REGION_END_A = 2'd2
  } region_t;

endpackage

### src/psd_ifs.sv
// ----------------------------------------------------------------------------
// psd_ifs: request and result channels of the point-segment distance unit
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface psd_in_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] end_a_x;
  logic signed [COORD_WIDTH-1:0] end_a_y;
  logic signed [COORD_WIDTH-1:0] end_b_x;
  logic signed [COORD_WIDTH-1:0] end_b_y;

  modport source (output valid, point_x, point_y, end_a_x, end_a_y, end_b_x, end_b_y,
                  input ready);
  modport sink   (input valid, point_x, point_y, end_a_x, end_a_y, end_b_x, end_b_y,
                  output ready);
endinterface

interface psd_out_if;
  logic        valid;
  logic        ready;
  logic [25:0] distance;
  logic [1:0]  region;

  modport source (output valid, distance, region, input ready);
  modport sink   (input valid, distance, region, output ready);
endinterface

### src/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front: vector setup for the distance unit
// Differences, products, region decision and the radicand/divisor pair that
// the root chain takes apart. Five registered stages with bubble collapsing.
// ----------------------------------------------------------------------------
module psd_front import psd_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int EW          = 24,
  parameter int DW          = EW + 1,
  parameter int NW          = 4 * DW,
  parameter int LW          = 2 * DW + 1
) (
  input  logic            clk,
  input  logic            rst_n,
  psd_in_if.sink          in_if,
  output logic            f_valid,
  input  logic            f_ready,
  output logic [NW-1:0]   f_num,
  output logic [LW-1:0]   f_len,
  output region_t         f_region
);

  localparam int PW = 2 * DW;
  localparam int SW = 2 * DW + 1;

  function automatic logic signed [DW-1:0] sx(input logic [COORD_WIDTH-1:0] v);
    return $signed({v[EW-1], v[EW-1:0]});
  endfunction

  logic [4:0] v_r;
  logic [4:0] rdy;

  assign rdy[4]      = !v_r[4] || f_ready;
  assign rdy[3]      = !v_r[3] || rdy[4];
  assign rdy[2]      = !v_r[2] || rdy[3];
  assign rdy[1]      = !v_r[1] || rdy[2];
  assign rdy[0]      = !v_r[0] || rdy[1];
  assign in_if.ready = rdy[0];
  assign f_valid     = v_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_if.valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
      if (rdy[4]) v_r[4] <= v_r[3];
    end
  end

  // stage 1: difference vectors
  logic signed [DW-1:0] ab_x_r, ab_y_r, pb_x_r, pb_y_r, pa_x_r, pa_y_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ab_x_r <= sx(in_if.end_a_x) - sx(in_if.end_b_x);
      ab_y_r <= sx(in_if.end_a_y) - sx(in_if.end_b_y);
      pb_x_r <= sx(in_if.point_x) - sx(in_if.end_b_x);
      pb_y_r <= sx(in_if.point_y) - sx(in_if.end_b_y);
      pa_x_r <= sx(in_if.point_x) - sx(in_if.end_a_x);
      pa_y_r <= sx(in_if.point_y) - sx(in_if.end_a_y);
    end
  end

  // stage 2: products
  logic signed [PW-1:0] ab_xx_r, ab_yy_r, dot_x_r, dot_y_r, crs_a_r, crs_b_r;
  logic signed [PW-1:0] pb_xx_r, pb_yy_r, pa_xx_r, pa_yy_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      ab_xx_r <= ab_x_r * ab_x_r;
      ab_yy_r <= ab_y_r * ab_y_r;
      dot_x_r <= ab_x_r * pb_x_r;
      dot_y_r <= ab_y_r * pb_y_r;
      crs_a_r <= ab_x_r * pb_y_r;
      crs_b_r <= ab_y_r * pb_x_r;
      pb_xx_r <= pb_x_r * pb_x_r;
      pb_yy_r <= pb_y_r * pb_y_r;
      pa_xx_r <= pa_x_r * pa_x_r;
      pa_yy_r <= pa_y_r * pa_y_r;
    end
  end

  // stage 3: sums
  logic signed [SW-1:0] len2_r, dot_r, cross_r, eb_r, ea_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      len2_r  <= SW'(ab_xx_r) + SW'(ab_yy_r);
      dot_r   <= SW'(dot_x_r) + SW'(dot_y_r);
      cross_r <= SW'(crs_a_r) - SW'(crs_b_r);
      eb_r    <= SW'(pb_xx_r) + SW'(pb_yy_r);
      ea_r    <= SW'(pa_xx_r) + SW'(pa_yy_r);
    end
  end

  // stage 4: region, end distance squared, cross^2 partial products
  region_t              region_nxt;
  logic signed [SW-1:0] cross_mag;
  logic [PW-1:0]        cmag;

  always_comb begin
    priority if (len2_r == '0 || dot_r < 0) begin
      region_nxt = REGION_END_B;
    end else if (dot_r > len2_r) begin
      region_nxt = REGION_END_A;
    end else begin
      region_nxt = REGION_PERP;
    end
  end

  assign cross_mag = (cross_r < 0) ? -cross_r : cross_r;
  assign cmag      = cross_mag[PW-1:0];

  region_t       region4_r;
  logic [LW-1:0] endsq_r, len4_r;
  logic [PW-1:0] hh_r, hl_r, ll_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      region4_r <= region_nxt;
      endsq_r   <= (region_nxt == REGION_END_A) ? ea_r : eb_r;
      len4_r    <= len2_r;
      hh_r      <= cmag[PW-1:DW] * cmag[PW-1:DW];
      hl_r      <= cmag[PW-1:DW] * cmag[DW-1:0];
      ll_r      <= cmag[DW-1:0] * cmag[DW-1:0];
    end
  end

  // stage 5: radicand and divisor for the root chain
  logic [NW-1:0] cr2;

  assign cr2 = (NW'(hh_r) << (2 * DW)) + (NW'(hl_r) << (DW + 1)) + NW'(ll_r);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      f_region <= region4_r;
      if (region4_r == REGION_PERP) begin
        f_num <= cr2;
        f_len <= len4_r;
      end else begin
        f_num <= NW'(endsq_r);
        f_len <= LW'(1);
      end
    end
  end

endmodule

### src/psd_root_cell.sv
// ----------------------------------------------------------------------------
// psd_root_cell: one bit of floor(sqrt(num / len))
// Tries bit BIT of the root against the running remainder and hands the
// updated remainder, root and root*len to the next cell.
// ----------------------------------------------------------------------------
module psd_root_cell import psd_pkg::*; #(
  parameter int BIT = 0,
  parameter int DW  = 25,
  parameter int LW  = 2 * DW + 1,
  parameter int TW  = 4 * DW + 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  logic [TW-1:0] up_rem,
  input  logic [TW-1:0] up_acc,
  input  logic [LW-1:0] up_len,
  input  logic [DW-1:0] up_root,
  input  region_t       up_region,
  output logic          dn_valid,
  input  logic          dn_ready,
  output logic [TW-1:0] dn_rem,
  output logic [TW-1:0] dn_acc,
  output logic [LW-1:0] dn_len,
  output logic [DW-1:0] dn_root,
  output region_t       dn_region
);

  logic          valid_r;
  logic [TW-1:0] rem_r, acc_r, rem_nxt, acc_nxt;
  logic [LW-1:0] len_r;
  logic [DW-1:0] root_r, root_nxt;
  region_t       region_r;
  logic [TW-1:0] term;
  logic          take;

  // (d + 2^b)^2 * L - d^2 * L = (d*L) << (b+1) + L << 2b
  assign term = (up_acc << (BIT + 1)) + (TW'(up_len) << (2 * BIT));
  assign take = term <= up_rem;

  always_comb begin
    rem_nxt  = up_rem;
    acc_nxt  = up_acc;
    root_nxt = up_root;
    if (take) begin
      rem_nxt       = up_rem - term;
      acc_nxt       = up_acc + (TW'(up_len) << BIT);
      root_nxt[BIT] = 1'b1;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      rem_r    <= rem_nxt;
      acc_r    <= acc_nxt;
      len_r    <= up_len;
      root_r   <= root_nxt;
      region_r <= up_region;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_rem    = rem_r;
  assign dn_acc    = acc_r;
  assign dn_len    = len_r;
  assign dn_root   = root_r;
  assign dn_region = region_r;

endmodule

### src/point_segment_distance_unit.sv
// ----------------------------------------------------------------------------
// point_segment_distance_unit: distance from a point to a 2-D segment
// Top level: setup stages followed by a chain of root cells.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the result side does not stall and returns
// one result per request, in order. Requests pass through the 5 setup stages
// and then a chain of root cells, one per bit of the root; every stage passes
// an item on each cycle and holds it while the result side stalls.
module point_segment_distance_unit import psd_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  psd_in_if.sink     in_if,
  psd_out_if.source  out_if
);

  localparam int EW  = (COORD_WIDTH > 30) ? 30 : COORD_WIDTH;
  localparam int DW  = EW + 1;
  localparam int NW  = 4 * DW;
  localparam int LW  = 2 * DW + 1;
  localparam int TW  = 4 * DW + 2;
  localparam int SAT = (DW > DIST_WIDTH) ? DW : DIST_WIDTH;

  logic          c_valid [DW+1];
  logic          c_ready [DW+1];
  logic [TW-1:0] c_rem   [DW+1];
  logic [TW-1:0] c_acc   [DW+1];
  logic [LW-1:0] c_len   [DW+1];
  logic [DW-1:0] c_root  [DW+1];
  region_t       c_region[DW+1];
  logic [NW-1:0] f_num;

  psd_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .EW          (EW),
    .DW          (DW),
    .NW          (NW),
    .LW          (LW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .f_valid  (c_valid[0]),
    .f_ready  (c_ready[0]),
    .f_num    (f_num),
    .f_len    (c_len[0]),
    .f_region (c_region[0])
  );

  assign c_rem[0]  = TW'(f_num);
  assign c_acc[0]  = '0;
  assign c_root[0] = '0;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    psd_root_cell #(
      .BIT (DW - 1 - i),
      .DW  (DW),
      .LW  (LW),
      .TW  (TW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (c_valid[i]),
      .up_ready  (c_ready[i]),
      .up_rem    (c_rem[i]),
      .up_acc    (c_acc[i]),
      .up_len    (c_len[i]),
      .up_root   (c_root[i]),
      .up_region (c_region[i]),
      .dn_valid  (c_valid[i+1]),
      .dn_ready  (c_ready[i+1]),
      .dn_rem    (c_rem[i+1]),
      .dn_acc    (c_acc[i+1]),
      .dn_len    (c_len[i+1]),
      .dn_root   (c_root[i+1]),
      .dn_region (c_region[i+1])
    );
  end

  logic [SAT-1:0] root_ext;

  assign root_ext        = SAT'(c_root[DW]);
  assign out_if.valid    = c_valid[DW];
  assign c_ready[DW]     = out_if.ready;
  assign out_if.distance = (root_ext > SAT'(DIST_MAX)) ? DIST_MAX : root_ext[DIST_WIDTH-1:0];
  assign out_if.region   = c_region[DW];

endmodule
